// ----- hdl/dledf_pkg.sv -----
// Shared types, byte codes and the byte-wide CRC-16 step for the DLE deframer.
// No dependencies; every other file of the block imports this package.
package dledf_pkg;

    localparam logic [7:0]  SYN_BYTE = 8'h16;
    localparam logic [7:0]  DLE_BYTE = 8'h10;
    localparam logic [7:0]  ETX_BYTE = 8'h03;
    localparam logic [2:0]  HDR_LEN = 3'd5;
    localparam logic [2:0]  HDR_CRC_START = 3'd3;
    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    localparam logic [2:0] KIND_DATA = 3'd0;
    localparam logic [2:0] KIND_GOOD = 3'd1;
    localparam logic [2:0] KIND_HDR_ERR = 3'd2;
    localparam logic [2:0] KIND_TRL_ERR = 3'd3;
    localparam logic [2:0] KIND_CRC_ERR = 3'd4;

    // One received byte held between the input register and the parser.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_rx_item;

    // Expected header byte at a given position; positions past the end return 0x00.
    function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
        logic [7:0] val;
        case (pos)
            3'd0:    val = 8'h16;
            3'd1:    val = 8'h10;
            3'd2:    val = 8'h02;
            3'd3:    val = 8'h00;
            3'd4:    val = 8'h17;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    // MSB-first CRC-16 update over one byte; unrolls to an XOR network.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- hdl/dle_frame_deframer_crc16_top.sv -----
// Top level of the DLE frame deframer with CRC-16/BUYPASS check.
// Depends on dledf_pkg, dledf_in_reg and dledf_parser.
//
// Usage:
//   The slave channel takes one raw byte from the serial link per transfer.
//   The block hunts for the header 16 10 02 00 17, strips DLE stuffing from
//   the payload and ends the payload at DLE ETX, followed by the CRC high
//   byte, the CRC low byte and a closing 0x16.
//   The master channel carries results: tuser gives the kind (payload byte,
//   frame good, header error, trailer error, crc mismatch), tlast marks the
//   result that closes a frame or reports an error. Bytes that cause no
//   result (hunting, header, escapes, CRC bytes) are consumed silently.
//   A result is loaded into the result register when its byte leaves the
//   input register. Throughput: one byte per cycle while no result waits;
//   the CRC step is a byte-wide XOR network between the input register
//   and the state/result register.
//   Stall: while a result waits for the receiver, one more byte is taken
//   into the input register, then the slave tready drops until the result
//   is transferred out. Nothing is dropped.
//   Reset (i_rst_n low, synchronous): both registers empty, hunting for the
//   header, running CRC and received CRC cleared.
module dle_frame_deframer_crc16_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [7:0] payload_byte, [23:8] crc_calc, [39:24] crc_read
    output logic [2:0]  o_m_tuser,   // [2:0] kind
    output logic        o_m_tlast    // frame_last
);
    import dledf_pkg::*;

    t_rx_item    w_item;
    logic        w_advance;
    logic [7:0]  w_payload;
    logic [15:0] w_crc_calc;
    logic [15:0] w_crc_read;

    // Hold the incoming byte until the parser can take it.
    dledf_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (i_s_tvalid),
        .i_tdata   (i_s_tdata),
        .o_tready  (o_s_tready),
        .i_advance (w_advance),
        .o_item    (w_item)
    );

    // Advance the frame state and register one result per byte at most.
    dledf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_out_ready (i_m_tready),
        .o_advance   (w_advance),
        .o_valid     (o_m_tvalid),
        .o_kind      (o_m_tuser),
        .o_payload   (w_payload),
        .o_crc_calc  (w_crc_calc),
        .o_crc_read  (w_crc_read),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = {w_crc_read, w_crc_calc, w_payload};

endmodule

// ----- hdl/dledf_in_reg.sv -----
// Input register of the DLE deframer: captures one byte per transfer.
// Depends on dledf_pkg for the item struct.
module dledf_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tvalid,
    input  logic [7:0]         i_tdata,
    output logic               o_tready,
    input  logic               i_advance,
    output dledf_pkg::t_rx_item o_item
);
    import dledf_pkg::*;

    t_rx_item r_item;

    // Free when empty or when the held byte moves on this cycle.
    assign o_tready = !r_item.valid || i_advance;
    assign o_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (o_tready) begin
            r_item.valid <= i_tvalid;
            if (i_tvalid) begin
                r_item.data <= i_tdata;
            end
        end
    end

endmodule

// ----- hdl/dledf_parser.sv -----
// Frame parser of the DLE deframer: header hunt, unstuffing, CRC and the result register.
// Depends on dledf_pkg for codes, the item struct and the CRC step.
module dledf_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dledf_pkg::t_rx_item i_item,
    input  logic                i_out_ready,
    output logic                o_advance,
    output logic                o_valid,
    output logic [2:0]          o_kind,
    output logic [7:0]          o_payload,
    output logic [15:0]         o_crc_calc,
    output logic [15:0]         o_crc_read,
    output logic                o_last
);
    import dledf_pkg::*;

    typedef enum logic [2:0] {
        ST_HUNT    = 3'd0,
        ST_HEADER  = 3'd1,
        ST_BODY    = 3'd2,
        ST_CRC_HI  = 3'd3,
        ST_CRC_LO  = 3'd4,
        ST_TRAILER = 3'd5
    } t_state;

    t_state      r_state, n_state;
    logic [2:0]  r_hpos, n_hpos;
    logic [15:0] r_crc, n_crc;
    logic        r_esc, n_esc;
    logic [7:0]  r_crc_hi, n_crc_hi;
    logic [7:0]  r_crc_lo, n_crc_lo;

    logic        r_valid, n_valid;
    logic [2:0]  r_kind, n_kind;
    logic [7:0]  r_payload, n_payload;
    logic [15:0] r_crc_calc, n_crc_calc;
    logic [15:0] r_crc_read, n_crc_read;
    logic        r_last, n_last;

    logic [7:0]  b;
    logic [15:0] rd;

    assign o_advance  = !r_valid || i_out_ready;
    assign b          = i_item.data;
    assign rd         = {r_crc_hi, r_crc_lo};

    assign o_valid    = r_valid;
    assign o_kind     = r_kind;
    assign o_payload  = r_payload;
    assign o_crc_calc = r_crc_calc;
    assign o_crc_read = r_crc_read;
    assign o_last     = r_last;

    always_comb begin
        n_state    = r_state;
        n_hpos     = r_hpos;
        n_crc      = r_crc;
        n_esc      = r_esc;
        n_crc_hi   = r_crc_hi;
        n_crc_lo   = r_crc_lo;
        n_valid    = r_valid && !o_advance;
        n_kind     = r_kind;
        n_payload  = r_payload;
        n_crc_calc = r_crc_calc;
        n_crc_read = r_crc_read;
        n_last     = r_last;

        if (i_item.valid && o_advance) begin
            n_valid    = 1'b0;
            n_kind     = KIND_DATA;
            n_payload  = 8'h00;
            n_crc_calc = 16'h0000;
            n_crc_read = 16'h0000;
            n_last     = 1'b0;

            unique case (r_state)
                ST_HEADER: begin
                    if (r_hpos >= HDR_LEN || b != hdr_byte(r_hpos)) begin
                        n_state = ST_HUNT;
                        n_hpos  = 3'd0;
                        n_valid = 1'b1;
                        n_kind  = KIND_HDR_ERR;
                        n_last  = 1'b1;
                    end else begin
                        if (r_hpos >= HDR_CRC_START) begin
                            n_crc = crc16_byte(r_crc, b);
                        end
                        n_hpos = r_hpos + 3'd1;
                        if (r_hpos + 3'd1 == HDR_LEN) begin
                            n_state = ST_BODY;
                            n_esc   = 1'b0;
                        end
                    end
                end
                ST_BODY: begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                        if (b == ETX_BYTE) begin
                            n_state = ST_CRC_HI;
                        end else begin
                            // Both bytes of the escape pair enter the CRC.
                            n_crc     = crc16_byte(crc16_byte(r_crc, DLE_BYTE), b);
                            n_valid   = 1'b1;
                            n_payload = b;
                        end
                    end else if (b == DLE_BYTE) begin
                        n_esc = 1'b1;
                    end else begin
                        n_crc     = crc16_byte(r_crc, b);
                        n_valid   = 1'b1;
                        n_payload = b;
                    end
                end
                ST_CRC_HI: begin
                    n_crc_hi = b;
                    n_state  = ST_CRC_LO;
                end
                ST_CRC_LO: begin
                    n_crc_lo = b;
                    n_state  = ST_TRAILER;
                end
                ST_TRAILER: begin
                    n_state    = ST_HUNT;
                    n_hpos     = 3'd0;
                    n_esc      = 1'b0;
                    n_valid    = 1'b1;
                    n_last     = 1'b1;
                    n_crc_calc = r_crc;
                    n_crc_read = rd;
                    // A bad closing byte outranks the CRC compare.
                    if (b != SYN_BYTE) begin
                        n_kind = KIND_TRL_ERR;
                    end else if (r_crc != rd) begin
                        n_kind = KIND_CRC_ERR;
                    end else begin
                        n_kind = KIND_GOOD;
                    end
                end
                default: begin
                    n_esc = 1'b0;
                    if (b == SYN_BYTE) begin
                        n_state = ST_HEADER;
                        n_hpos  = 3'd1;
                        n_crc   = CRC_INIT;
                    end else begin
                        n_state = ST_HUNT;
                        n_hpos  = 3'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_HUNT;
            r_hpos   <= 3'd0;
            r_crc    <= CRC_INIT;
            r_esc    <= 1'b0;
            r_crc_hi <= 8'h00;
            r_crc_lo <= 8'h00;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_hpos   <= n_hpos;
            r_crc    <= n_crc;
            r_esc    <= n_esc;
            r_crc_hi <= n_crc_hi;
            r_crc_lo <= n_crc_lo;
            r_valid  <= n_valid;
        end
        r_kind     <= n_kind;
        r_payload  <= n_payload;
        r_crc_calc <= n_crc_calc;
        r_crc_read <= n_crc_read;
        r_last     <= n_last;
    end

endmodule
